FILE: rtl/core/mbps_pkg.sv
package mbps_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 5;
	localparam int MASK_W     = 16;
	localparam int COUNT_W    = 16;
	localparam int ADDR_W     = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES  = 3'd4;

	typedef logic [7:0] byte_t;

endpackage

FILE: rtl/core/masked_byte_pattern_scanner_core.sv
// channel | direction | handshake              | payload
// --------+-----------+------------------------+------------------------------------------
// in      | input     | in_valid / in_stall    | data_byte, section_first, section_base
// out     | output    | out_valid / out_stall  | match_address, limit_reached
// cfg     | input     | cfg_wr_en              | cfg_index, cfg_wdata
//
// One word per clock in steady state while no held result is stalled; an accepted word loads
// the input register, and its compare and address add are then loaded into the result register
// when the output advances, which makes the result valid.
// arst_n clears window, counters and the stop flag; config registers go to their defaults.
// in_stall rises only when the input register is full and a held result is stalled.
module masked_byte_pattern_scanner_core #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              section_first,
	input  logic [mbps_pkg::ADDR_W-1:0]       section_base,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mbps_pkg::ADDR_W-1:0]       match_address,
	output logic                              limit_reached,
	input  logic                              cfg_wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic [63:0]                     pat_lo_q;
	logic [63:0]                     pat_hi_q;
	logic [mbps_pkg::MASK_W-1:0]     care_q;
	logic [mbps_pkg::LEN_W-1:0]      len_cfg_q;
	logic [mbps_pkg::COUNT_W-1:0]    max_q;

	logic                            valid_s1;
	mbps_pkg::byte_t                 byte_s1;
	logic                            first_s1;
	logic [mbps_pkg::ADDR_W-1:0]     base_s1;

	mbps_pkg::byte_t                 win_q [MAX_PATTERN];
	mbps_pkg::byte_t                 win_n [MAX_PATTERN];
	logic [CNT_W-1:0]                bis_q;
	logic [CNT_W-1:0]                bis_n;
	logic [mbps_pkg::ADDR_W-1:0]     base_q;
	logic [mbps_pkg::ADDR_W-1:0]     base_n;
	logic [mbps_pkg::ADDR_W-1:0]     offset_q;
	logic [mbps_pkg::ADDR_W-1:0]     offset_n;
	logic [mbps_pkg::COUNT_W-1:0]    found_q;
	logic [mbps_pkg::COUNT_W-1:0]    found_n;
	logic                            stopped_q;

	logic                            out_valid_q;
	logic [mbps_pkg::ADDR_W-1:0]     addr_q;
	logic                            limit_q;

	logic [mbps_pkg::LEN_W-1:0]      len_c;
	logic [127:0]                    pat_all;
	logic                            window_ok;
	logic                            hit;
	logic                            limit_c;
	logic [mbps_pkg::ADDR_W-1:0]     addr_c;
	logic                            advance;
	logic                            step;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;
	assign pat_all  = {pat_hi_q, pat_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			care_q    <= '0;
			len_cfg_q <= mbps_pkg::LEN_W'(1);
			max_q     <= mbps_pkg::COUNT_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mbps_pkg::CFG_PATTERN_LOW:  pat_lo_q  <= cfg_wdata;
				mbps_pkg::CFG_PATTERN_HIGH: pat_hi_q  <= cfg_wdata;
				mbps_pkg::CFG_CARE_MASK:    care_q    <= cfg_wdata[mbps_pkg::MASK_W-1:0];
				mbps_pkg::CFG_PATTERN_LEN:  len_cfg_q <= cfg_wdata[mbps_pkg::LEN_W-1:0];
				mbps_pkg::CFG_MAX_MATCHES:  max_q     <= cfg_wdata[mbps_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= data_byte;
			first_s1 <= section_first;
			base_s1  <= section_base;
		end
	end

	always_comb begin
		win_n[0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_n[k] = win_q[k-1];
		end
		if (first_s1) begin
			base_n   = base_s1;
			offset_n = '0;
			bis_n    = CNT_W'(1);
		end else begin
			base_n   = base_q;
			offset_n = offset_q + 1'b1;
			bis_n    = (bis_q < CNT_W'(MAX_PATTERN)) ? bis_q + 1'b1 : bis_q;
		end
		len_c = (len_cfg_q > mbps_pkg::LEN_W'(MAX_PATTERN)) ?
			mbps_pkg::LEN_W'(MAX_PATTERN) : len_cfg_q;
	end

	// pattern byte i lines up with the window entry len-1-i
	always_comb begin
		logic [mbps_pkg::LEN_W-1:0] pos;
		window_ok = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pos = len_c - mbps_pkg::LEN_W'(i) - mbps_pkg::LEN_W'(1);
			if ((mbps_pkg::LEN_W'(i) < len_c) && care_q[i] &&
			    (win_n[pos[IDX_W-1:0]] != pat_all[8*i +: 8])) begin
				window_ok = 1'b0;
			end
		end
	end

	assign hit = !stopped_q && (len_c != '0) && (max_q != '0) &&
		(mbps_pkg::LEN_W'(bis_n) >= len_c) && window_ok;
	assign found_n = found_q + 1'b1;
	assign limit_c = found_n >= max_q;
	assign addr_c  = base_n + offset_n - mbps_pkg::ADDR_W'(len_c) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= '0;
			end
			bis_q     <= '0;
			base_q    <= '0;
			offset_q  <= '0;
			found_q   <= '0;
			stopped_q <= 1'b0;
		end else if (step) begin
			win_q    <= win_n;
			bis_q    <= bis_n;
			base_q   <= base_n;
			offset_q <= offset_n;
			if (hit) begin
				found_q <= found_n;
				if (limit_c) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			addr_q  <= addr_c;
			limit_q <= limit_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = addr_q;
	assign limit_reached = limit_q;

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stop flag cleared while running");

	a_limit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && limit_q) |-> stopped_q)
		else $error("limit word issued without stopping");

	a_count_on_word: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q != $past(found_q)) |-> out_valid_q)
		else $error("match count moved without a result word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

endmodule

FILE: verif/scan_checker.sv
`timescale 1ns / 100ps

module scan_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic [7:0]                              data_byte,
	input  logic                                    section_first,
	input  logic [mbps_pkg::ADDR_W-1:0]             section_base,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic [mbps_pkg::ADDR_W-1:0]             match_address,
	input  logic                                    limit_reached,
	input  logic                                    cfg_wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	output int                                      errors,
	output int                                      outstanding
);
	import mbps_pkg::*;

	localparam int WINDOW = 16;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              last;
	} hit_t;

	hit_t hits_due[$];
	int   fails;

	logic [127:0]       pattern;
	logic [MASK_W-1:0]  care;
	logic [LEN_W-1:0]   plen;
	logic [COUNT_W-1:0] limit;

	byte_t              win [WINDOW];
	logic [4:0]         seen;
	logic [ADDR_W-1:0]  base;
	logic [ADDR_W-1:0]  offs;
	logic [COUNT_W-1:0] found;
	logic               halted;

	// shifts one word into the window; returns 1 with the hit when the window matches
	function automatic logic scan_byte(input byte_t d, input logic first,
		input logic [ADDR_W-1:0] b, output hit_t h);
		int k;
		int len;
		logic ok;
		for (k = WINDOW - 1; k > 0; k--)
			win[k] = win[k-1];
		win[0] = d;
		if (first) begin
			base = b;
			offs = '0;
			seen = 5'd1;
		end else begin
			offs = offs + 1'b1;
			if (seen < WINDOW)
				seen = seen + 1'b1;
		end
		len = (plen > WINDOW) ? WINDOW : int'(plen);
		h = '0;
		if (halted || len == 0 || limit == '0 || seen < len)
			return 1'b0;
		ok = 1'b1;
		for (k = 0; k < len; k++)
			if (care[k] && win[len-1-k] != pattern[8*k +: 8])
				ok = 1'b0;
		if (!ok)
			return 1'b0;
		found = found + 1'b1;
		h.addr = base + offs - ADDR_W'(len - 1);
		h.last = (found >= limit);
		if (h.last)
			halted = 1'b1;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		hit_t h;
		hit_t want;
		if (!arst_n) begin
			pattern = '0;
			care    = '0;
			plen    = LEN_W'(1);
			limit   = COUNT_W'(1);
			for (int k = 0; k < WINDOW; k++)
				win[k] = '0;
			seen    = '0;
			base    = '0;
			offs    = '0;
			found   = '0;
			halted  = 1'b0;
			hits_due.delete();
			fails   = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PATTERN_LOW:  pattern[63:0]   = cfg_wdata;
					CFG_PATTERN_HIGH: pattern[127:64] = cfg_wdata;
					CFG_CARE_MASK:    care  = cfg_wdata[MASK_W-1:0];
					CFG_PATTERN_LEN:  plen  = cfg_wdata[LEN_W-1:0];
					CFG_MAX_MATCHES:  limit = cfg_wdata[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				if (scan_byte(data_byte, section_first, section_base, h))
					hits_due = {hits_due, h};
			if (out_valid && !out_stall) begin
				if (hits_due.size() == 0) begin
					$display("%0t: unexpected hit, expected none, got address %h limit %b",
						$time, match_address, limit_reached);
					fails++;
				end else begin
					want = hits_due.pop_front();
					if (match_address !== want.addr) begin
						$display("%0t: match_address expected %h, got %h",
							$time, want.addr, match_address);
						fails++;
					end
					if (limit_reached !== want.last) begin
						$display("%0t: limit_reached expected %b, got %b",
							$time, want.last, limit_reached);
						fails++;
					end
				end
			end
			errors      <= fails;
			outstanding <= hits_due.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mbps_pkg::*;

	localparam int ITEMS  = 800;
	localparam int PHASES = 10;
	localparam int LIMIT  = 400000;
	localparam int DRAIN  = 8;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  in_stall;
	byte_t                 data_byte     = '0;
	logic                  section_first = 1'b0;
	logic [ADDR_W-1:0]     section_base  = '0;
	logic                  out_valid;
	logic                  out_stall     = 1'b0;
	logic [ADDR_W-1:0]     match_address;
	logic                  limit_reached;
	logic                  cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = CFG_PATTERN_LOW;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

	int errors;
	int outstanding;
	int cycle_count = 0;
	int sent = 0;
	bit calm = 1'b0;
	bit fresh = 1'b0;

	logic [127:0]      pat;
	logic [MASK_W-1:0] care;
	int                span;

	always #6 clk = ~clk;

	masked_byte_pattern_scanner_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .section_first(section_first), .section_base(section_base),
		.out_valid(out_valid), .out_stall(out_stall),
		.match_address(match_address), .limit_reached(limit_reached),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	scan_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .section_first(section_first), .section_base(section_base),
		.out_valid(out_valid), .out_stall(out_stall),
		.match_address(match_address), .limit_reached(limit_reached),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		@(posedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 18)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic put_word(input byte_t d, input logic first, input logic [ADDR_W-1:0] b);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= d;
		section_first <= first;
		section_base  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	function automatic logic [ADDR_W-1:0] pick_base();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic emit(input byte_t d);
		put_word(d, fresh, pick_base());
		fresh = 1'b0;
	endtask

	// waits for outstanding hits, then lets the pipeline empty of words with none
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic load_regs(input logic [63:0] lo, input logic [63:0] hi,
		input logic [MASK_W-1:0] m, input logic [LEN_W-1:0] l,
		input logic [COUNT_W-1:0] mx, input bit stray);
		if (stray) begin
			cfg_index <= CFG_MAX_MATCHES + CFG_IDX_W'($urandom_range(1, 3));
			cfg_wdata <= {$urandom, $urandom};
			cfg_wr_en <= 1'b1;
			@(posedge clk);
		end
		cfg_index <= CFG_PATTERN_LOW;
		cfg_wdata <= lo;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_index <= CFG_PATTERN_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_index <= CFG_CARE_MASK;
		cfg_wdata <= CFG_DATA_W'(m);
		@(posedge clk);
		cfg_index <= CFG_PATTERN_LEN;
		cfg_wdata <= CFG_DATA_W'(l);
		@(posedge clk);
		cfg_index <= CFG_MAX_MATCHES;
		cfg_wdata <= CFG_DATA_W'(mx);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pat  = {hi, lo};
		care = m;
		span = (l > 16) ? 16 : int'(l);
	endtask

	// one occurrence of the pattern with random wildcard bytes, optionally spoilt
	task automatic plant(input bit spoil);
		int n;
		int bad;
		byte_t d;
		n   = (span == 0) ? $urandom_range(1, 16) : span;
		bad = spoil ? $urandom_range(0, n - 1) : -1;
		for (int k = 0; k < n; k++) begin
			d = care[k] ? pat[8*k +: 8] : byte_t'($urandom);
			if (k == bad)
				d = d ^ byte_t'($urandom_range(1, 255));
			emit(d);
		end
	endtask

	task automatic roam(input int quota);
		int stop_at;
		stop_at = sent + quota;
		while (sent < stop_at) begin
			if ($urandom_range(0, 9) < 6) begin
				fresh = ($urandom_range(0, 1) == 0);
				repeat ($urandom_range(0, 4)) emit(byte_t'($urandom));
				plant($urandom_range(0, 4) == 0);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					fresh = ($urandom_range(0, 7) == 0);
					emit(byte_t'($urandom));
				end
			end
		end
	endtask

	initial begin
		logic [63:0]        lo;
		logic [63:0]        hi;
		logic [MASK_W-1:0]  m;
		logic [LEN_W-1:0]   l;
		logic [COUNT_W-1:0] mx;
		bit                 stray;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pattern 00 ?? FF, middle byte a wildcard
		load_regs(64'h0000_0000_00FF_5A00, '1, 16'h0005, 5'd3, 16'hFFFF, 1'b0);
		// words ahead of any section start
		put_word(8'h00, 1'b0, '0);
		put_word(8'h11, 1'b0, '1);
		put_word(8'hFF, 1'b0, '0);
		put_word(8'h00, 1'b1, 32'hFFFF_FFFF);
		put_word(8'hAB, 1'b0, '0);
		put_word(8'hFF, 1'b0, '0);
		// window straddling a section boundary must not hit
		put_word(8'h00, 1'b1, 32'h7FFF_FFFE);
		put_word(8'hEE, 1'b1, '0);
		put_word(8'hFF, 1'b0, '0);
		put_word(8'hFF, 1'b0, '0);
		// address wraps past the top
		put_word(8'h00, 1'b1, 32'hFFFF_FFFE);
		put_word(8'h01, 1'b0, '0);
		put_word(8'hFF, 1'b0, '0);
		put_word(8'h00, 1'b0, '0);
		put_word(8'h00, 1'b0, '0);
		put_word(8'hFF, 1'b0, '0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			lo    = {$urandom, $urandom};
			hi    = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: m = '0;
				1: m = '1;
				default: m = MASK_W'($urandom);
			endcase
			l     = LEN_W'($urandom_range(1, 16));
			mx    = 16'hFFFF;
			stray = 1'b0;
			case (p)
				0: begin
					l = 5'd16;
					m = '1;
				end
				1: l = 5'd0;
				2: l = 5'd31;
				3: mx = '0;
				4: begin
					l = 5'd1;
					m = '0;
				end
				5: stray = 1'b1;
				PHASES - 1: begin
					// limit below the hits so far: the next hit stops the scan
					l    = LEN_W'($urandom_range(1, 4));
					mx   = 16'd1;
					calm = 1'b1;
				end
				default: ;
			endcase
			load_regs(lo, hi, m, l, mx, stray);
			roam(ITEMS / PHASES);
		end
		settle();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
